### hw/rtl/m3i_pkg.sv
package m3i_pkg;

  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_ELEMS  = 9;

  localparam int DATA_W = ((NUM_ELEMS * ELEM_WIDTH + 7) / 8) * 8;

  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int COF_W  = 2 * ELEM_WIDTH + 1;
  localparam int HI_W   = COF_W - ELEM_WIDTH;
  localparam int PART_W = 2 * ELEM_WIDTH + 1;
  localparam int DET_W  = 3 * ELEM_WIDTH + 1;
  localparam int NMAG_W = 2 * ELEM_WIDTH;
  localparam int DMAG_W = 3 * ELEM_WIDTH;
  localparam int DEN_W  = DMAG_W + 1;
  localparam int NUM_SH = 2 * FRAC_BITS + 1;
  localparam int REM_W  = ((NMAG_W + NUM_SH > DMAG_W) ? (NMAG_W + NUM_SH) : DMAG_W) + 1;
  localparam int CMP_W  = ((REM_W > DEN_W + ELEM_WIDTH) ? REM_W : (DEN_W + ELEM_WIDTH)) + 1;
  localparam int DIV_STAGES = ELEM_WIDTH + 2;

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [COF_W-1:0]      cof_t;
  typedef logic signed [PART_W-1:0]     part_t;
  typedef logic signed [DET_W-1:0]      det_t;

  localparam elem_t ELEM_MAX = elem_t'({1'b0, {(ELEM_WIDTH-1){1'b1}}});
  localparam elem_t ELEM_MIN = elem_t'({1'b1, {(ELEM_WIDTH-1){1'b0}}});

  typedef struct packed {
    logic valid;
    logic tpose;
  } pipe_ctl_t;

  typedef struct packed {
    logic valid;
    logic singular;
  } res_ctl_t;

endpackage

### hw/rtl/m3i_cofactor.sv
module m3i_cofactor (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  m3i_pkg::pipe_ctl_t ctl_in,
  input  m3i_pkg::elem_t     elem [9],
  output m3i_pkg::pipe_ctl_t ctl_out,
  output m3i_pkg::elem_t     row0 [3],
  output m3i_pkg::cof_t      cof [9]
);
  import m3i_pkg::*;

  prod_t     prod_a [9];
  prod_t     prod_b [9];
  elem_t     row0_s1 [3];
  pipe_ctl_t ctl_s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s1  <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl_s1  <= ctl_in;
      ctl_out <= ctl_s1;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    localparam int R1 = (r + 1) % 3;
    localparam int R2 = (r + 2) % 3;
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;
      always_ff @(posedge clk) begin
        if (en) begin
          prod_a[r*3+c] <= elem[R1*3+C1] * elem[R2*3+C2];
          prod_b[r*3+c] <= elem[R1*3+C2] * elem[R2*3+C1];
          cof[r*3+c]    <= COF_W'(prod_a[r*3+c]) - COF_W'(prod_b[r*3+c]);
        end
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_row0
    always_ff @(posedge clk) begin
      if (en) begin
        row0_s1[c] <= elem[c];
        row0[c]    <= row0_s1[c];
      end
    end
  end

endmodule

### hw/rtl/m3i_det.sv
module m3i_det (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  m3i_pkg::pipe_ctl_t ctl_in,
  input  m3i_pkg::elem_t     row0 [3],
  input  m3i_pkg::cof_t      cof_in [9],
  output m3i_pkg::pipe_ctl_t ctl_out,
  output m3i_pkg::cof_t      cof_out [9],
  output m3i_pkg::det_t      det
);
  import m3i_pkg::*;

  part_t     part_lo [3];
  part_t     part_hi [3];
  det_t      term [3];
  cof_t      cof_s3 [9];
  cof_t      cof_s4 [9];
  pipe_ctl_t ctl_s3;
  pipe_ctl_t ctl_s4;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s3  <= '0;
      ctl_s4  <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl_s3  <= ctl_in;
      ctl_s4  <= ctl_s3;
      ctl_out <= ctl_s4;
    end
  end

  // split each cofactor into a signed high half and an unsigned low half
  for (genvar c = 0; c < 3; c++) begin : g_term
    always_ff @(posedge clk) begin
      if (en) begin
        part_lo[c] <= row0[c] * $signed({1'b0, cof_in[c][ELEM_WIDTH-1:0]});
        part_hi[c] <= row0[c] * $signed(cof_in[c][COF_W-1:ELEM_WIDTH]);
        term[c]    <= (DET_W'(part_hi[c]) <<< ELEM_WIDTH) + DET_W'(part_lo[c]);
      end
    end
  end

  for (genvar i = 0; i < 9; i++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en) begin
        cof_s3[i]  <= cof_in[i];
        cof_s4[i]  <= cof_s3[i];
        cof_out[i] <= cof_s4[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det <= term[0] + term[1] + term[2];
    end
  end

endmodule

### hw/rtl/m3i_div.sv
module m3i_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  m3i_pkg::pipe_ctl_t ctl_in,
  input  m3i_pkg::cof_t      cof [9],
  input  m3i_pkg::det_t      det,
  output m3i_pkg::res_ctl_t  res_ctl,
  output m3i_pkg::elem_t     res [9]
);
  import m3i_pkg::*;

  logic [REM_W-1:0]      rem  [DIV_STAGES][9];
  logic [ELEM_WIDTH-1:0] quo  [DIV_STAGES][9];
  logic                  ovf  [DIV_STAGES][9];
  logic                  neg  [DIV_STAGES][9];
  logic [DEN_W-1:0]      den  [DIV_STAGES];
  logic                  sing [DIV_STAGES];
  logic                  vld  [DIV_STAGES];

  logic [DMAG_W-1:0] dmag;
  det_t              det_neg;

  always_comb begin
    det_neg = -det;
    dmag    = det[DET_W-1] ? det_neg[DMAG_W-1:0] : det[DMAG_W-1:0];
  end

  // prep stage: magnitudes, signs, rounding offset folded into the dividend
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den[0]  <= {dmag, 1'b0};
      sing[0] <= (det == '0);
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_pr
    for (genvar c = 0; c < 3; c++) begin : g_pc
      cof_t              src;
      cof_t              src_neg;
      logic [NMAG_W-1:0] nmag;
      always_comb begin
        src     = ctl_in.tpose ? cof[r*3+c] : cof[c*3+r];
        src_neg = -src;
        nmag    = src[COF_W-1] ? src_neg[NMAG_W-1:0] : src[NMAG_W-1:0];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem[0][r*3+c] <= (REM_W'(nmag) << NUM_SH) + REM_W'(dmag);
          quo[0][r*3+c] <= '0;
          ovf[0][r*3+c] <= 1'b0;
          neg[0][r*3+c] <= src[COF_W-1] ^ det[DET_W-1];
        end
      end
    end
  end

  // one quotient bit per stage, the first stage only checks for overflow
  for (genvar s = 1; s < DIV_STAGES; s++) begin : g_stage
    localparam int K = DIV_STAGES - 1 - s;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den[s]  <= den[s-1];
        sing[s] <= sing[s-1];
      end
    end

    for (genvar l = 0; l < 9; l++) begin : g_lane
      logic [CMP_W-1:0]      dsh;
      logic                  ge;
      logic [ELEM_WIDTH-1:0] quo_next;
      always_comb begin
        dsh      = CMP_W'(den[s-1]) << K;
        ge       = CMP_W'(rem[s-1][l]) >= dsh;
        quo_next = quo[s-1][l];
        if (K < ELEM_WIDTH) begin
          quo_next[K % ELEM_WIDTH] = ge;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          neg[s][l] <= neg[s-1][l];
          quo[s][l] <= quo_next;
          if (K == ELEM_WIDTH) begin
            ovf[s][l] <= ge;
            rem[s][l] <= rem[s-1][l];
          end else begin
            ovf[s][l] <= ovf[s-1][l];
            rem[s][l] <= ge ? (rem[s-1][l] - dsh[REM_W-1:0]) : rem[s-1][l];
          end
        end
      end
    end
  end

  // output register: saturate, apply sign, zero on singular
  always_ff @(posedge clk) begin
    if (rst) begin
      res_ctl.valid <= 1'b0;
    end else if (en) begin
      res_ctl.valid <= vld[DIV_STAGES-1];
    end
    if (en) begin
      res_ctl.singular <= sing[DIV_STAGES-1];
    end
  end

  for (genvar l = 0; l < 9; l++) begin : g_out
    logic [ELEM_WIDTH-1:0] q;
    logic                  n;
    logic                  sat;
    elem_t                 val;
    always_comb begin
      q   = quo[DIV_STAGES-1][l];
      n   = neg[DIV_STAGES-1][l];
      sat = ovf[DIV_STAGES-1][l] ||
            (n ? (q[ELEM_WIDTH-1] && (q[ELEM_WIDTH-2:0] != '0)) : q[ELEM_WIDTH-1]);
      if (sing[DIV_STAGES-1]) begin
        val = '0;
      end else if (sat) begin
        val = n ? ELEM_MIN : ELEM_MAX;
      end else begin
        val = n ? elem_t'(-q) : elem_t'(q);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        res[l] <= val;
      end
    end
  end

endmodule

### hw/rtl/matrix3_inverse.sv
// Pipeline: 2 cofactor, 3 determinant, 1 setup and 33 divider stages (the first
// checks for overflow, each other gives one quotient bit), 1 output register.
// Throughput: one matrix per cycle; the whole pipeline holds while an output
// word waits and shifts as soon as it is taken.
// Reset (rst, synchronous): clears all valid bits and sets transpose_result to 0.
module matrix3_inverse (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // in_r0c0, in_r0c1, in_r0c2, in_r1c0 .. in_r2c2, 32 bits each
  input  logic [m3i_pkg::DATA_W-1:0] s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // out_r0c0, out_r0c1, out_r0c2, out_r1c0 .. out_r2c2, 32 bits each
  output logic [m3i_pkg::DATA_W-1:0] m_tdata,
  // singular
  output logic                       m_tuser,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_data
);
  import m3i_pkg::*;

  logic      en;
  logic      transpose_result;
  pipe_ctl_t ctl_in;
  pipe_ctl_t ctl_cof;
  pipe_ctl_t ctl_det;
  res_ctl_t  res_ctl;
  elem_t     elem [9];
  elem_t     row0 [3];
  cof_t      cof [9];
  cof_t      cof_det [9];
  det_t      det;
  elem_t     res [9];

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      transpose_result <= 1'b0;
    end else if (cfg_valid) begin
      transpose_result <= cfg_data;
    end
  end

  assign ctl_in.valid = s_tvalid;
  assign ctl_in.tpose = transpose_result;

  for (genvar i = 0; i < 9; i++) begin : g_io
    assign elem[i] = s_tdata[i*ELEM_WIDTH +: ELEM_WIDTH];
    assign m_tdata[i*ELEM_WIDTH +: ELEM_WIDTH] = res[i];
  end
  if (DATA_W > 9 * ELEM_WIDTH) begin : g_pad
    assign m_tdata[DATA_W-1:9*ELEM_WIDTH] = '0;
  end

  m3i_cofactor u_cofactor (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_in),
    .elem    (elem),
    .ctl_out (ctl_cof),
    .row0    (row0),
    .cof     (cof)
  );

  m3i_det u_det (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_cof),
    .row0    (row0),
    .cof_in  (cof),
    .ctl_out (ctl_det),
    .cof_out (cof_det),
    .det     (det)
  );

  m3i_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_det),
    .cof     (cof_det),
    .det     (det),
    .res_ctl (res_ctl),
    .res     (res)
  );

  assign m_tvalid = res_ctl.valid;
  assign m_tuser  = res_ctl.singular;

endmodule

### hw/rtl/m3i_check.sv
module m3i_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [m3i_pkg::DATA_W-1:0] m_tdata,
  input logic                       m_tuser
);
  import m3i_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("singular result carries nonzero elements");

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while output path is free");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind matrix3_inverse m3i_check u_check (.*);
